### hw/rtl/pmt_pkg.sv
package pmt_pkg;

  typedef enum logic [2:0] {
    OP_JOIN      = 3'd0,
    OP_LEAVE     = 3'd1,
    OP_KEEPALIVE = 3'd2,
    OP_SEND_OK   = 3'd3,
    OP_SEND_FAIL = 3'd4,
    OP_OTHER     = 3'd5
  } pmt_op_e;

  typedef enum logic [2:0] {
    OC_IGNORED   = 3'd0,
    OC_JOINED    = 3'd1,
    OC_REFRESHED = 3'd2,
    OC_LEFT      = 3'd3,
    OC_FULL      = 3'd4,
    OC_FAILED    = 3'd5,
    OC_EVICTED   = 3'd6,
    OC_SUCCESS   = 3'd7
  } pmt_outcome_e;

  typedef enum logic [1:0] {
    REG_STREAM_ID = 2'd0,
    REG_ROOM_CODE = 2'd1,
    REG_MAGIC     = 2'd2,
    REG_FAIL_LIM  = 2'd3
  } pmt_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_APPLY
  } pmt_state_e;

  typedef struct packed {
    logic alloc;
    logic release_slot;
    logic stamp;
    logic streak_we;
  } pmt_wr_t;

  typedef struct packed {
    logic hit;
    logic free;
  } pmt_hit_t;

  localparam int unsigned MacW       = 48;
  localparam int unsigned StampW     = 32;
  localparam int unsigned StreakW    = 8;
  localparam logic [StreakW-1:0] StreakMax  = 8'hFF;
  localparam logic [7:0]         FailLimRst = 8'd8;

endpackage

### hw/rtl/pmt_store.sv
module pmt_store
  import pmt_pkg::*;
#(
  parameter int unsigned Slots = 8,
  parameter int unsigned IdxW  = 3,
  parameter int unsigned CntW  = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [IdxW-1:0]    rd_idx_i,
  output logic               rd_use_o,
  output logic [MacW-1:0]    rd_mac_o,
  output logic [StreakW-1:0] rd_streak_o,
  input  pmt_wr_t            wr_i,
  input  logic [IdxW-1:0]    wr_idx_i,
  input  logic [MacW-1:0]    wr_mac_i,
  input  logic [StampW-1:0]  wr_now_i,
  input  logic [StreakW-1:0] wr_streak_i,
  output logic [CntW-1:0]    active_o
);

  logic [Slots-1:0]   in_use_q;
  logic [CntW-1:0]    active_q;
  logic               rd_use_q;
  logic [MacW-1:0]    rd_mac_q;
  logic [StreakW-1:0] rd_streak_q;

  logic [MacW-1:0]    mac_mem    [Slots];
  logic [StampW-1:0]  seen_mem   [Slots];
  logic [StreakW-1:0] streak_mem [Slots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      active_q <= '0;
    end else begin
      if (wr_i.alloc) begin
        in_use_q[wr_idx_i] <= 1'b1;
      end else if (wr_i.release_slot) begin
        in_use_q[wr_idx_i] <= 1'b0;
      end
      if (wr_i.alloc && !wr_i.release_slot) begin
        active_q <= active_q + CntW'(1);
      end else if (wr_i.release_slot && !wr_i.alloc) begin
        active_q <= active_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.alloc) begin
      mac_mem[wr_idx_i] <= wr_mac_i;
    end
    if (rd_en_i) begin
      rd_mac_q <= mac_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.stamp) begin
      seen_mem[wr_idx_i] <= wr_now_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.streak_we) begin
      streak_mem[wr_idx_i] <= wr_streak_i;
    end
    if (rd_en_i) begin
      rd_streak_q <= streak_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_use_q <= in_use_q[rd_idx_i];
    end
  end

  assign rd_use_o    = rd_use_q;
  assign rd_mac_o    = rd_mac_q;
  assign rd_streak_o = rd_streak_q;
  assign active_o    = active_q;

endmodule

### hw/rtl/pmt_match.sv
module pmt_match
  import pmt_pkg::*;
#(
  parameter int unsigned IdxW = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               cmp_en_i,
  input  logic [IdxW-1:0]    cmp_idx_i,
  input  logic               rd_use_i,
  input  logic [MacW-1:0]    rd_mac_i,
  input  logic [StreakW-1:0] rd_streak_i,
  input  logic [MacW-1:0]    key_mac_i,
  output pmt_hit_t           hit_o,
  output logic [IdxW-1:0]    hit_idx_o,
  output logic [IdxW-1:0]    free_idx_o,
  output logic [StreakW-1:0] streak_o
);

  logic               hit_q;
  logic               free_q;
  logic [IdxW-1:0]    hit_idx_q;
  logic [IdxW-1:0]    free_idx_q;
  logic [StreakW-1:0] streak_q;
  logic               equal;

  assign equal = (rd_mac_i == key_mac_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (start_i) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmp_en_i) begin
      if (rd_use_i && equal && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (!rd_use_i && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_i && rd_use_i && equal && !hit_q) begin
      hit_idx_q <= cmp_idx_i;
      streak_q  <= rd_streak_i;
    end
    if (cmp_en_i && !rd_use_i && !free_q) begin
      free_idx_q <= cmp_idx_i;
    end
  end

  assign hit_o.hit  = hit_q;
  assign hit_o.free = free_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign streak_o   = streak_q;

endmodule

### hw/rtl/peer_membership_table.sv
// Channel   Dir  Beat content
// s_axis    in   tdata: peer_mac, message_magic, message_room, message_stream, now_us
//                tuser: opcode, frame_complete
// m_axis    out  tdata: slot_index, slot_found, add_radio_peer, drop_radio_peer,
//                active_count; tuser: outcome
// cfg       in   register write, index 0 to 3, no read-back
//
// A lookup beat reaches the result register through ST_SCAN, ST_LAST and ST_APPLY:
// one slot is read and compared per cycle, then ST_APPLY applies the update once the
// output register is free. Beats that need no lookup go from acceptance to ST_APPLY.
// The input is ready again once the result is loaded, so lookup beats do not overlap.
// The output register holds its beat while m_axis_tready is low; a new beat may be
// accepted meanwhile. Reset empties the table at once and sets fail_limit to 8.
module peer_membership_table
  import pmt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // peer_mac[47:0], message_magic[55:48], message_room[87:56],
  // message_stream[119:88], now_us[151:120]
  input  logic [151:0] s_axis_tdata,
  // opcode[2:0], frame_complete[3]
  input  logic [3:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot_index[2:0], slot_found[3], add_radio_peer[4], drop_radio_peer[5],
  // active_count[9:6], zero[15:10]
  output logic [15:0]  m_axis_tdata,
  // outcome[2:0]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int unsigned IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(TABLE_SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_SLOTS - 1);

  logic [31:0] stream_id_q;
  logic [31:0] room_code_q;
  logic [7:0]  magic_q;
  logic [7:0]  fail_lim_q;

  pmt_state_e state_q, state_d;

  pmt_op_e           op_q;
  logic              pass_q;
  logic [MacW-1:0]   mac_q;
  logic [StampW-1:0] now_q;

  logic [IdxW-1:0] idx_q;
  logic            cmp_en_q;
  logic [IdxW-1:0] cmp_idx_q;

  logic               accept;
  logic               need_scan;
  logic               pass_in;
  logic               rd_en;
  logic               out_free;
  logic               apply_go;
  logic               rd_use;
  logic [MacW-1:0]    rd_mac;
  logic [StreakW-1:0] rd_streak;
  pmt_hit_t           hit;
  logic [IdxW-1:0]    hit_idx;
  logic [IdxW-1:0]    free_idx;
  logic [StreakW-1:0] streak;
  logic [CntW-1:0]    active;
  logic [StreakW-1:0] streak_inc;

  pmt_outcome_e       outcome;
  logic               found;
  logic [IdxW-1:0]    sel_idx;
  logic               add_peer;
  logic               drop_peer;
  pmt_wr_t            wr_dec;
  pmt_wr_t            wr;
  logic [StreakW-1:0] wr_streak;
  logic [CntW-1:0]    active_after;
  logic [IdxW+2:0]    sel_ext;
  logic [CntW+3:0]    active_ext;

  logic         m_valid_q;
  logic [15:0]  m_data_q;
  logic [2:0]   m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_id_q <= '0;
      room_code_q <= '0;
      magic_q     <= '0;
      fail_lim_q  <= FailLimRst;
    end else if (cfg_we_i) begin
      unique case (pmt_reg_e'(cfg_addr_i))
        REG_STREAM_ID: stream_id_q <= cfg_wdata_i;
        REG_ROOM_CODE: room_code_q <= cfg_wdata_i;
        REG_MAGIC:     magic_q     <= cfg_wdata_i[7:0];
        REG_FAIL_LIM:  fail_lim_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pass_in       = s_axis_tuser[3] && (s_axis_tdata[55:48] == magic_q) &&
                         (s_axis_tdata[87:56] == room_code_q) &&
                         (s_axis_tdata[119:88] == stream_id_q);

  always_comb begin
    need_scan = 1'b0;
    case (pmt_op_e'(s_axis_tuser[2:0]))
      OP_JOIN, OP_LEAVE, OP_KEEPALIVE: need_scan = pass_in;
      OP_SEND_OK, OP_SEND_FAIL:        need_scan = 1'b1;
      default:                         need_scan = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= pmt_op_e'(s_axis_tuser[2:0]);
      pass_q <= pass_in;
      mac_q  <= s_axis_tdata[47:0];
      now_q  <= s_axis_tdata[151:120];
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;
  assign apply_go = (state_q == ST_APPLY) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = need_scan ? ST_SCAN : ST_APPLY;
      ST_SCAN:  if (idx_q == LastIdx) state_d = ST_LAST;
      ST_LAST:  state_d = ST_APPLY;
      ST_APPLY: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      cmp_en_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmp_en_q <= rd_en;
      if (state_q == ST_SCAN) begin
        idx_q <= idx_q + IdxW'(1);
      end else begin
        idx_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
  end

  always_comb begin
    rd_en = (state_q == ST_SCAN);
  end

  pmt_store #(
    .Slots (TABLE_SLOTS),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_idx_i    (idx_q),
    .rd_use_o    (rd_use),
    .rd_mac_o    (rd_mac),
    .rd_streak_o (rd_streak),
    .wr_i        (wr),
    .wr_idx_i    (sel_idx),
    .wr_mac_i    (mac_q),
    .wr_now_i    (now_q),
    .wr_streak_i (wr_streak),
    .active_o    (active)
  );

  pmt_match #(
    .IdxW (IdxW)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .cmp_en_i    (cmp_en_q),
    .cmp_idx_i   (cmp_idx_q),
    .rd_use_i    (rd_use),
    .rd_mac_i    (rd_mac),
    .rd_streak_i (rd_streak),
    .key_mac_i   (mac_q),
    .hit_o       (hit),
    .hit_idx_o   (hit_idx),
    .free_idx_o  (free_idx),
    .streak_o    (streak)
  );

  assign streak_inc = streak + StreakW'(1);

  always_comb begin
    outcome   = OC_IGNORED;
    found     = 1'b0;
    sel_idx   = hit_idx;
    add_peer  = 1'b0;
    drop_peer = 1'b0;
    wr_dec    = '0;
    wr_streak = '0;
    case (op_q)
      OP_JOIN, OP_KEEPALIVE: begin
        if (pass_q) begin
          if (hit.hit) begin
            outcome          = OC_REFRESHED;
            found            = 1'b1;
            add_peer         = (op_q == OP_JOIN);
            wr_dec.stamp     = (op_q == OP_KEEPALIVE);
            wr_dec.streak_we = 1'b1;
          end else if (hit.free) begin
            outcome          = OC_JOINED;
            found            = 1'b1;
            sel_idx          = free_idx;
            add_peer         = 1'b1;
            wr_dec.alloc     = 1'b1;
            wr_dec.stamp     = 1'b1;
            wr_dec.streak_we = 1'b1;
          end else begin
            outcome = OC_FULL;
          end
        end
      end
      OP_LEAVE: begin
        if (pass_q) begin
          outcome   = OC_LEFT;
          drop_peer = 1'b1;
          if (hit.hit) begin
            found               = 1'b1;
            wr_dec.release_slot = 1'b1;
          end
        end
      end
      OP_SEND_OK: begin
        if (hit.hit) begin
          outcome          = OC_SUCCESS;
          found            = 1'b1;
          wr_dec.streak_we = 1'b1;
        end
      end
      OP_SEND_FAIL: begin
        if (hit.hit) begin
          found   = 1'b1;
          outcome = OC_FAILED;
          if (streak != StreakMax) begin
            if (streak_inc >= fail_lim_q) begin
              outcome             = OC_EVICTED;
              wr_dec.release_slot = 1'b1;
            end else begin
              wr_dec.streak_we = 1'b1;
              wr_streak        = streak_inc;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign wr = apply_go ? wr_dec : '0;

  always_comb begin
    active_after = active;
    if (wr_dec.alloc) begin
      active_after = active + CntW'(1);
    end else if (wr_dec.release_slot) begin
      active_after = active - CntW'(1);
    end
  end

  assign sel_ext    = {3'b000, found ? sel_idx : IdxW'(0)};
  assign active_ext = {4'b0000, active_after};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (apply_go) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_go) begin
      m_data_q <= {6'b000000, active_ext[3:0], drop_peer, add_peer, found, sel_ext[2:0]};
      m_user_q <= outcome;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
